@@ rtl/renc_pkg.sv @@
package renc_pkg;

    localparam int RANGE_BITS_DEF = 64;
    localparam int FREQ_W         = 16;
    localparam int CNT_W          = 24;
    localparam int MAX_OUT        = 8;
    localparam int NOUT_W         = $clog2(MAX_OUT + 1);
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;

    localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(12500000);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LIMIT = 2'd1;
    localparam logic [1:0] ERR_FREQ  = 2'd2;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic REG_LIMIT = 1'b0;

endpackage

@@ rtl/range_encoder_carryless.sv @@
// Carryless range encoder, one symbol or one flush per input item.
// Input channel (i_in_valid / o_in_ready): i_kind selects encode or finish;
// encode items carry i_cum_freq, i_sym_freq and i_total_freq.
// Output channel (o_out_valid / i_out_ready): one item per coded byte,
// o_last on the final byte of an input, o_error flags the output limit or
// bad frequencies (bad encode inputs give one byte-less item, error set).
// Config: APB register 0 at address 0 holds the output byte limit.
// Sequence: an encode is accepted, then passes through the restoring
// divider (one quotient bit per cycle), the shift-add multiplier (one
// frequency bit per cycle) and the low update, then renormalizes and emits
// its bytes. A finish flushes RANGE_BITS/8 bytes. One item is in work at a
// time; o_in_ready is high only between items.
// Reset clears low to zero, range to all ones, the byte count to zero and
// restores the default limit. A stalled receiver holds the output register
// and one staged byte; the coder waits until the output register frees.
module range_encoder_carryless #(
    parameter int RANGE_BITS = renc_pkg::RANGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [renc_pkg::FREQ_W-1:0]   i_cum_freq,
    input  logic [renc_pkg::FREQ_W-1:0]   i_sym_freq,
    input  logic [renc_pkg::FREQ_W-1:0]   i_total_freq,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last,
    output logic [1:0]                    o_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [renc_pkg::APB_AW-1:0]   paddr,
    input  logic [renc_pkg::APB_DW-1:0]   pwdata,
    output logic [renc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import renc_pkg::*;

    localparam int W           = RANGE_BITS;
    localparam int STEP_W      = $clog2(RANGE_BITS);
    localparam int FLUSH_BYTES = RANGE_BITS / 8;
    localparam logic [W-1:0] BOT      = W'(1) << (W - 16);
    localparam logic [W-1:0] BOT_MASK = BOT - W'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BAD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_NORM = 3'd5;

    logic [2:0]        r_state, n_state;
    logic              r_kind, n_kind;
    logic [W-1:0]      r_low, n_low;
    logic [W-1:0]      r_range, n_range;
    logic [W-1:0]      r_dq, n_dq;
    logic [FREQ_W-1:0] r_rem, n_rem;
    logic [FREQ_W-1:0] r_tot, n_tot;
    logic [FREQ_W-1:0] r_cum, n_cum;
    logic [FREQ_W-1:0] r_freq, n_freq;
    logic [W-1:0]      r_acc_c, n_acc_c;
    logic [W-1:0]      r_acc_f, n_acc_f;
    logic [STEP_W-1:0] r_step, n_step;
    logic [NOUT_W-1:0] r_nout, n_nout;
    logic [CNT_W-1:0]  r_bw, n_bw;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic              r_pv, n_pv;
    logic [7:0]        r_pb, n_pb;
    logic              r_pe, n_pe;
    logic              r_ov, n_ov;
    logic [7:0]        r_ob, n_ob;
    logic              r_ol, n_ol;
    logic [1:0]        r_oe, n_oe;

    logic              in_acc;
    logic              bad;
    logic              out_free;
    logic              push;
    logic [7:0]        push_byte;
    logic              push_last;
    logic [1:0]        push_err;
    logic [FREQ_W:0]   div_t;
    logic              div_ge;
    logic [FREQ_W:0]   div_d;
    logic [W-1:0]      hi;
    logic              settled;
    logic              narrow;
    logic [NOUT_W-1:0] nout_lim;
    logic              go;
    logic [W-1:0]      clip_range;
    logic [CNT_W-1:0]  bw_inc;
    logic              cfg_wr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_last      = r_ol;
    assign o_error     = r_oe;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_LIMIT) ? APB_DW'(r_limit) : '0;

    assign bad = (i_total_freq == '0) || (i_sym_freq == '0) ||
                 (({1'b0, i_cum_freq} + {1'b0, i_sym_freq}) > {1'b0, i_total_freq});

    assign div_t  = {r_rem, r_dq[W-1]};
    assign div_ge = div_t >= {1'b0, r_tot};
    assign div_d  = div_t - {1'b0, r_tot};

    assign hi         = r_low + r_range;
    assign settled    = ((r_low ^ hi) >> (W - 8)) == '0;
    assign narrow     = r_range < BOT;
    assign clip_range = settled ? r_range : ((W'(0) - r_low) & BOT_MASK);
    assign nout_lim   = (r_kind == KIND_FINISH) ? NOUT_W'(FLUSH_BYTES) : NOUT_W'(MAX_OUT);
    assign go         = (r_nout < nout_lim) && ((r_kind == KIND_FINISH) || settled || narrow);
    assign bw_inc     = (r_bw == CNT_MAX) ? r_bw : r_bw + CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_low     = r_low;
        n_range   = r_range;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_tot     = r_tot;
        n_cum     = r_cum;
        n_freq    = r_freq;
        n_acc_c   = r_acc_c;
        n_acc_f   = r_acc_f;
        n_step    = r_step;
        n_nout    = r_nout;
        n_bw      = r_bw;
        n_limit   = r_limit;
        n_pv      = r_pv;
        n_pb      = r_pb;
        n_pe      = r_pe;
        push      = 1'b0;
        push_byte = r_pb;
        push_last = 1'b0;
        push_err  = r_pe ? ERR_LIMIT : ERR_NONE;

        if (cfg_wr && paddr[2] == REG_LIMIT) begin
            n_limit = pwdata[CNT_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind = i_kind;
                    n_cum  = i_cum_freq;
                    n_freq = i_sym_freq;
                    n_tot  = i_total_freq;
                    n_dq   = r_range;
                    n_rem  = '0;
                    n_step = STEP_W'(W - 1);
                    n_nout = '0;
                    if (i_kind == KIND_FINISH) begin
                        n_state = S_NORM;
                    end else if (bad) begin
                        n_state = S_BAD;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_BAD: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_byte = '0;
                    push_last = 1'b1;
                    push_err  = ERR_FREQ;
                    n_state   = S_IDLE;
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_d[FREQ_W-1:0] : div_t[FREQ_W-1:0];
                n_dq  = {r_dq[W-2:0], div_ge};
                if (r_step == '0) begin
                    n_acc_c = '0;
                    n_acc_f = '0;
                    n_step  = STEP_W'(FREQ_W - 1);
                    n_state = S_MUL;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_MUL: begin
                n_acc_c = (r_acc_c << 1) + (r_cum[FREQ_W-1] ? r_dq : '0);
                n_acc_f = (r_acc_f << 1) + (r_freq[FREQ_W-1] ? r_dq : '0);
                n_cum   = r_cum << 1;
                n_freq  = r_freq << 1;
                if (r_step == '0) begin
                    n_state = S_ADD;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_ADD: begin
                n_low   = r_low + r_acc_c;
                n_range = r_acc_f;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (go) begin
                    if (!r_pv || out_free) begin
                        push   = r_pv;
                        n_pv   = 1'b1;
                        n_pb   = r_low[W-1 -: 8];
                        n_pe   = bw_inc > r_limit;
                        n_bw   = bw_inc;
                        n_low  = r_low << 8;
                        n_nout = r_nout + NOUT_W'(1);
                        if (r_kind == KIND_ENCODE) begin
                            n_range = clip_range << 8;
                        end
                    end
                end else if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pv      = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ov = r_ov && !i_out_ready;
        n_ob = r_ob;
        n_ol = r_ol;
        n_oe = r_oe;
        if (push) begin
            n_ov = 1'b1;
            n_ob = push_byte;
            n_ol = push_last;
            n_oe = push_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_low   <= '0;
            r_range <= '1;
            r_bw    <= '0;
            r_limit <= LIMIT_RST;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_range <= n_range;
            r_bw    <= n_bw;
            r_limit <= n_limit;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_tot   <= n_tot;
        r_cum   <= n_cum;
        r_freq  <= n_freq;
        r_acc_c <= n_acc_c;
        r_acc_f <= n_acc_f;
        r_step  <= n_step;
        r_nout  <= n_nout;
        r_pb    <= n_pb;
        r_pe    <= n_pe;
        r_ob    <= n_ob;
        r_ol    <= n_ol;
        r_oe    <= n_oe;
    end

    // staged byte only lives while bytes are being produced
    a_pend_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_NORM))
        else $error("staged byte outside renormalization");

    a_bw_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_bw >= $past(r_bw)))
        else $error("byte count went backwards");

    a_nout_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_nout <= nout_lim))
        else $error("too many bytes for one item");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("output register overwritten");

endmodule
